// ===== hdl/multi_rate_tick_timebase_unit_defines.svh =====
// assertion macros for the multi-rate tick timebase checker
// no dependencies; included by the checker file only
`ifndef MULTI_RATE_TICK_TIMEBASE_UNIT_DEFINES_SVH
`define MULTI_RATE_TICK_TIMEBASE_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define MRTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define MRTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mrtt_pkg.sv =====
// shared types and constants for the multi-rate tick timebase
// no dependencies; imported by every module of the block
package mrtt_pkg;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 104;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [31:0] FAST_STEP_US = 32'd50;
  localparam logic [10:0] REM_STEP_US = 11'd50;
  localparam logic [10:0] MS_US = 11'd1000;
  localparam logic [13:0] ADC_STEP_US = 14'd100;
  localparam logic [13:0] ADC_SPAN_US = 14'd10000;
  localparam logic [20:0] APP_STEP_US = 21'd100;
  localparam logic [19:0] MIN_INTERVAL_US = 20'd100;
  localparam logic [30:0] WRAP_LIMIT_RST = 31'd60000000;
  localparam logic [30:0] WRAP_MARGIN_RST = 31'd2000000;

  typedef enum logic [1:0] {
    SRC_FAST = 2'd0,
    SRC_SLOW = 2'd1,
    SRC_AUX  = 2'd2,
    SRC_SYS  = 2'd3
  } tick_src_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_APP_INTERVAL = 2'd0,
    REG_WRAP_LIMIT   = 2'd1,
    REG_WRAP_MARGIN  = 2'd2
  } cfg_reg_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [19:0] interval;  // already clamped to the minimum
    logic [30:0] limit;
    logic [31:0] bound;     // limit plus margin
  } cfg_t;

  // one result item, us_time in the lowest bits
  typedef struct packed {
    logic        sys_tick;
    logic        aux_tick;
    logic        app_tick;
    logic        adc_start;
    logic [31:0] fast_tick_count;
    logic [31:0] ms_time;
    logic [31:0] us_time;
  } result_t;

endpackage

// ===== hdl/mrtt_cfg.sv =====
// configuration registers for the multi-rate tick timebase
// depends on mrtt_pkg
module mrtt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [mrtt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mrtt_pkg::CFG_DATA_W-1:0] wr_data,
  output mrtt_pkg::cfg_t                   cfg
);
  import mrtt_pkg::*;

  logic [19:0] interval;
  logic [30:0] limit;
  logic [30:0] margin;
  logic [31:0] bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= MIN_INTERVAL_US;
      limit    <= WRAP_LIMIT_RST;
      margin   <= WRAP_MARGIN_RST;
      bound    <= {1'b0, WRAP_LIMIT_RST} + {1'b0, WRAP_MARGIN_RST};
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_APP_INTERVAL: begin
          interval <= (wr_data[19:0] < MIN_INTERVAL_US) ? MIN_INTERVAL_US : wr_data[19:0];
        end
        REG_WRAP_LIMIT: begin
          limit <= wr_data;
          bound <= {1'b0, wr_data} + {1'b0, margin};
        end
        REG_WRAP_MARGIN: begin
          margin <= wr_data;
          bound  <= {1'b0, limit} + {1'b0, wr_data};
        end
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  assign cfg.interval = interval;
  assign cfg.limit    = limit;
  assign cfg.bound    = bound;

endmodule

// ===== hdl/mrtt_step.sv =====
// timebase counters and their per-tick update
// depends on mrtt_pkg
module mrtt_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [1:0]        src,
  input  mrtt_pkg::cfg_t    cfg,
  output mrtt_pkg::result_t res
);
  import mrtt_pkg::*;

  logic [31:0] us_count, us_count_next;
  logic [10:0] ms_remainder, ms_remainder_next;
  logic [31:0] ms_count, ms_count_next;
  logic [31:0] fast_count, fast_count_next;
  logic [13:0] adc_count, adc_count_next;
  logic [20:0] app_count, app_count_next;
  logic [10:0] rem_sum;
  logic [13:0] adc_sum;
  logic [20:0] app_sum;
  logic        adc_pulse;
  logic        app_pulse;

  assign rem_sum = ms_remainder + REM_STEP_US;
  assign adc_sum = adc_count + ADC_STEP_US;
  assign app_sum = app_count + APP_STEP_US;

  always_comb begin
    us_count_next     = us_count;
    ms_remainder_next = ms_remainder;
    ms_count_next     = ms_count;
    fast_count_next   = fast_count;
    adc_count_next    = adc_count;
    app_count_next    = app_count;
    adc_pulse         = 1'b0;
    app_pulse         = 1'b0;
    case (tick_src_t'(src))
      SRC_FAST: begin
        fast_count_next = fast_count + 32'd1;
        if (us_count >= cfg.bound) begin
          us_count_next = us_count - {1'b0, cfg.limit};
        end else begin
          us_count_next = us_count + FAST_STEP_US;
        end
        if (rem_sum >= MS_US) begin
          ms_remainder_next = rem_sum - MS_US;
          ms_count_next     = ms_count + 32'd1;
        end else begin
          ms_remainder_next = rem_sum;
        end
      end
      SRC_SLOW: begin
        if (adc_sum > ADC_SPAN_US) begin
          adc_pulse      = 1'b1;
          adc_count_next = '0;
        end else begin
          adc_count_next = adc_sum;
        end
        if (app_sum > {1'b0, cfg.interval}) begin
          app_pulse      = 1'b1;
          app_count_next = app_sum - {1'b0, cfg.interval};
        end else begin
          app_count_next = app_sum;
        end
      end
      default: begin
        // aux and system ticks leave the counters alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      us_count     <= '0;
      ms_remainder <= '0;
      ms_count     <= '0;
      fast_count   <= '0;
      adc_count    <= '0;
      app_count    <= '0;
    end else if (advance) begin
      us_count     <= us_count_next;
      ms_remainder <= ms_remainder_next;
      ms_count     <= ms_count_next;
      fast_count   <= fast_count_next;
      adc_count    <= adc_count_next;
      app_count    <= app_count_next;
    end
  end

  assign res.us_time         = us_count_next;
  assign res.ms_time         = ms_count_next;
  assign res.fast_tick_count = fast_count_next;
  assign res.adc_start       = adc_pulse;
  assign res.app_tick        = app_pulse;
  assign res.aux_tick        = (tick_src_t'(src) == SRC_AUX);
  assign res.sys_tick        = (tick_src_t'(src) == SRC_SYS);

endmodule

// ===== hdl/multi_rate_tick_timebase_unit.sv =====
// top level of the multi-rate tick timebase
// depends on mrtt_pkg, mrtt_cfg and mrtt_step
//
// usage
//   s_axis carries one tick event per transfer, tick_source in tdata[1:0]:
//   fast 50 us tick, slow 100 us tick, auxiliary tick or system tick
//   m_axis returns exactly one result per tick: microsecond time, millisecond
//   count and fast tick count after that tick, plus the adc start, app tick,
//   aux and sys pulses
//   cfg_* writes app interval, wrap limit and wrap margin by index; it is
//   always ready and is meant to be used only while no tick is in flight
// timing
//   a tick transfer lands in the input register; once the output register is
//   free or draining, the counters update and the result is captured in the
//   output register, which offers it on m_axis
//   one tick per cycle is sustained while m_axis_tready is high; the update
//   from input to output register is a single pass of adders and compares
// reset
//   rst is synchronous, active high: counters clear, both registers empty,
//   configuration returns to 100 us interval, 60 s limit and 2 s margin
// stall
//   while m_axis_tready is low the result holds; one more tick is still taken
//   into the input register, then s_axis_tready drops until the output drains
module multi_rate_tick_timebase_unit (
  input  logic                             clk,
  input  logic                             rst,
  // slave stream: [1:0] tick_source, [7:2] zero
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mrtt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // master stream: [31:0] us_time, [63:32] ms_time, [95:64] fast_tick_count,
  // [96] adc_start, [97] app_tick, [98] aux_tick, [99] sys_tick, [103:100] zero
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mrtt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mrtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrtt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrtt_pkg::*;

  logic        in_valid;
  logic [1:0]  in_src;
  logic        out_valid;
  result_t     out_data;
  result_t     res;
  cfg_t        cfg;
  logic        advance;
  logic        s_xfer;

  // input register moves on when the output register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  mrtt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mrtt_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .src     (in_src),
    .cfg     (cfg),
    .res     (res)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // tick payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_src <= s_axis_tdata[1:0];
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_data};

endmodule

// ===== hdl/mrtt_checker.sv =====
// port-level checks for the multi-rate tick timebase
// depends on mrtt_pkg and multi_rate_tick_timebase_unit_defines.svh
`include "multi_rate_tick_timebase_unit_defines.svh"

module mrtt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mrtt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import mrtt_pkg::*;

  // a stalled result keeps its value
  `MRTT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // nothing offered right after reset
  `MRTT_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result offered after reset")

  // an empty output side never blocks the input side
  `MRTT_ASSERT(a_no_block, !m_axis_tvalid |-> s_axis_tready, "input stalled with output empty")

  // a tick comes from one source only, so at most one pulse group is set
  `MRTT_ASSERT(a_pulse_excl, m_axis_tvalid |-> !((m_axis_tdata[98] || m_axis_tdata[99]) && (m_axis_tdata[96] || m_axis_tdata[97])) && !(m_axis_tdata[98] && m_axis_tdata[99]), "pulses from two sources at once")

endmodule

bind multi_rate_tick_timebase_unit mrtt_checker u_mrtt_checker (.*);

// ===== bench/tb_top.sv =====
// self-checking bench for the multi-rate tick timebase: directed table, then random phases
// depends on mrtt_pkg and multi_rate_tick_timebase_unit; results checked against a local model
`timescale 1ns / 1ps

module tb_top;
  import mrtt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT = 23;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 130;
  localparam int SETTLE_CYCLES = 4;    // pipeline is two deep, leave some slack
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_AFTER = 500;     // results seen before the long back-pressure
  localparam int HOLD_CYCLES = 80;

  // timebase arithmetic
  localparam logic [31:0] STEP_FAST = 32'd50;
  localparam logic [10:0] STEP_REM = 11'd50;
  localparam logic [10:0] US_PER_MS = 11'd1000;
  localparam logic [13:0] STEP_ADC = 14'd100;
  localparam logic [13:0] ADC_PERIOD_US = 14'd10000;
  localparam logic [20:0] STEP_APP = 21'd100;
  localparam logic [19:0] INTERVAL_FLOOR = 20'd100;

  typedef enum logic [0:0] {
    ROW_TICK,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    tick_src_t   src;
    int          reps;
    bit          typed;
    result_t     want;
    cfg_reg_t    idx;
    logic [30:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_APP_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // no random idling on either side while set
  logic steady = 1'b0;

  multi_rate_tick_timebase_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the timebase: configuration and counters, reset values
  logic [19:0] app_interval = 20'd100;
  logic [30:0] wrap_limit = 31'd60000000;
  logic [30:0] wrap_margin = 31'd2000000;
  logic [31:0] us_cnt = '0;
  logic [10:0] ms_rem = '0;
  logic [31:0] ms_cnt = '0;
  logic [31:0] fast_cnt = '0;
  logic [13:0] adc_cnt = '0;
  logic [20:0] app_cnt = '0;

  // timebase snapshots still owed by the block, oldest first
  result_t timebase_q[$];
  stim_row_t directed_rows[$];
  int fail_count = 0;
  int results_seen = 0;

  // advance the local timebase by one tick and return the snapshot after it
  function automatic result_t advance_timebase(tick_src_t src);
    result_t r;
    logic [32:0] bound;
    logic [19:0] ival;
    r = '0;
    case (src)
      SRC_FAST: begin
        // limit plus margin needs the extra bit
        bound = {2'b00, wrap_limit} + {2'b00, wrap_margin};
        fast_cnt = fast_cnt + 32'd1;
        if ({1'b0, us_cnt} >= bound) begin
          us_cnt = us_cnt - {1'b0, wrap_limit};
        end else begin
          us_cnt = us_cnt + STEP_FAST;
        end
        ms_rem = ms_rem + STEP_REM;
        if (ms_rem >= US_PER_MS) begin
          ms_rem = ms_rem - US_PER_MS;
          ms_cnt = ms_cnt + 32'd1;
        end
      end
      SRC_SLOW: begin
        // an interval below the floor behaves as the floor
        ival = (app_interval < INTERVAL_FLOOR) ? INTERVAL_FLOOR : app_interval;
        adc_cnt = adc_cnt + STEP_ADC;
        if (adc_cnt > ADC_PERIOD_US) begin
          r.adc_start = 1'b1;
          adc_cnt = '0;
        end
        app_cnt = app_cnt + STEP_APP;
        if (app_cnt > {1'b0, ival}) begin
          r.app_tick = 1'b1;
          app_cnt = app_cnt - {1'b0, ival};
        end
      end
      default: ;
    endcase
    r.us_time = us_cnt;
    r.ms_time = ms_cnt;
    r.fast_tick_count = fast_cnt;
    r.aux_tick = (src == SRC_AUX);
    r.sys_tick = (src == SRC_SYS);
    return r;
  endfunction

  function automatic void add_ticks(tick_src_t src, int reps);
    stim_row_t row;
    row = '{kind: ROW_TICK, src: src, reps: reps, typed: 1'b0, want: '0,
            idx: REG_APP_INTERVAL, value: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(tick_src_t src, logic [31:0] us, logic [31:0] ms,
                                    logic [31:0] fc, logic adc, logic app);
    stim_row_t row;
    row = '{kind: ROW_TICK, src: src, reps: 1, typed: 1'b1, want: '0,
            idx: REG_APP_INTERVAL, value: '0};
    row.want.us_time = us;
    row.want.ms_time = ms;
    row.want.fast_tick_count = fc;
    row.want.adc_start = adc;
    row.want.app_tick = app;
    row.want.aux_tick = (src == SRC_AUX);
    row.want.sys_tick = (src == SRC_SYS);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, logic [30:0] value);
    stim_row_t row;
    row = '{kind: ROW_CFG, src: SRC_FAST, reps: 0, typed: 1'b0, want: '0,
            idx: idx, value: value};
    directed_rows.push_back(row);
  endfunction

  function automatic tick_src_t pick_source();
    int r;
    r = $urandom_range(99);
    if (r < 45) return SRC_FAST;
    if (r < 85) return SRC_SLOW;
    if (r < 93) return SRC_AUX;
    return SRC_SYS;
  endfunction

  // offer one tick; leaves tvalid high at the edge of the transfer
  task automatic put_tick(tick_src_t src, bit typed, result_t want);
    result_t r;
    r = advance_timebase(src);
    if (typed) r = want;
    timebase_q.push_back(r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_W-2){1'b0}}, src};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // register writes only once every owed result has come back
  task automatic write_reg(cfg_reg_t idx, logic [30:0] value);
    s_tvalid <= 1'b0;
    while (timebase_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_APP_INTERVAL: app_interval = value[19:0];
      REG_WRAP_LIMIT:   wrap_limit = value;
      REG_WRAP_MARGIN:  wrap_margin = value;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result side: random back-pressure, one long hold, field-by-field compare
  int hold_left = 0;
  bit hold_done = 1'b0;

  // long hold while the sender keeps offering, so the input side backs up
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER && s_tvalid) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin : result_checker
    result_t want;
    result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (timebase_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = timebase_q.pop_front();
          got = result_t'(m_tdata[$bits(result_t)-1:0]);
          check_field("us_time", want.us_time, got.us_time);
          check_field("ms_time", want.ms_time, got.ms_time);
          check_field("fast_tick_count", want.fast_tick_count, got.fast_tick_count);
          check_field("adc_start", 32'(want.adc_start), 32'(got.adc_start));
          check_field("app_tick", 32'(want.app_tick), 32'(got.app_tick));
          check_field("aux_tick", 32'(want.aux_tick), 32'(got.aux_tick));
          check_field("sys_tick", 32'(want.sys_tick), 32'(got.sys_tick));
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL multi_rate_tick_timebase_unit");
    $finish;
  end

  // main stimulus
  initial begin : stimulus
    logic [30:0] ph_interval[PHASES];
    logic [30:0] ph_limit[PHASES];
    logic [30:0] ph_margin[PHASES];
    int sel;

    // directed: reset values, every source, wrap, ms carry, interval floor,
    // largest limit and margin
    add_typed(SRC_FAST, 32'd50, 32'd0, 32'd1, 1'b0, 1'b0);
    add_typed(SRC_SLOW, 32'd50, 32'd0, 32'd1, 1'b0, 1'b0);
    add_typed(SRC_SLOW, 32'd50, 32'd0, 32'd1, 1'b0, 1'b1);
    add_typed(SRC_AUX, 32'd50, 32'd0, 32'd1, 1'b0, 1'b0);
    add_typed(SRC_SYS, 32'd50, 32'd0, 32'd1, 1'b0, 1'b0);
    add_cfg(REG_WRAP_LIMIT, 31'd50);
    add_cfg(REG_WRAP_MARGIN, 31'd0);
    add_typed(SRC_FAST, 32'd0, 32'd0, 32'd2, 1'b0, 1'b0);   // us time pulled back
    add_ticks(SRC_FAST, 17);
    add_typed(SRC_FAST, 32'd0, 32'd1, 32'd20, 1'b0, 1'b0);  // first ms carry
    add_cfg(REG_APP_INTERVAL, 31'd0);
    add_ticks(SRC_SLOW, 2);
    add_cfg(REG_WRAP_LIMIT, 31'h7FFF_FFFF);
    add_cfg(REG_WRAP_MARGIN, 31'h7FFF_FFFF);
    add_typed(SRC_FAST, 32'd50, 32'd1, 32'd21, 1'b0, 1'b0);

    // phase settings: defaults, extremes, a lowered interval after a long one,
    // a zero limit, masked high bits on the interval, then random ones
    ph_interval[0] = 31'd100;      ph_limit[0] = 31'd60000000; ph_margin[0] = 31'd2000000;
    ph_interval[1] = 31'd1000000;  ph_limit[1] = 31'd1;        ph_margin[1] = 31'd0;
    ph_interval[2] = 31'd1000;     ph_limit[2] = 31'h7FFF_FFFF; ph_margin[2] = 31'h7FFF_FFFF;
    ph_interval[3] = 31'd0;        ph_limit[3] = 31'd300;      ph_margin[3] = 31'd250;
    ph_interval[4] = 31'd99;       ph_limit[4] = 31'd0;        ph_margin[4] = 31'd100;
    ph_interval[5] = (31'd1 << 25) | 31'd1000;
    ph_limit[5] = 31'd777;
    ph_margin[5] = 31'h7FFF_FFFF;
    for (int p = 6; p < PHASES; p++) begin
      sel = $urandom_range(9);
      case (sel)
        0: ph_interval[p] = 31'($urandom_range(99));
        1: ph_interval[p] = 31'($urandom_range(1000000, 100));
        2: ph_interval[p] = {11'($urandom_range(2047)), 20'($urandom_range(1500, 100))};
        default: ph_interval[p] = 31'($urandom_range(1500, 100));
      endcase
      ph_limit[p] = 31'($urandom_range(3000));
      ph_margin[p] = 31'($urandom_range(3000));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        repeat (directed_rows[i].reps) begin
          put_tick(directed_rows[i].src, directed_rows[i].typed, directed_rows[i].want);
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_APP_INTERVAL, ph_interval[p]);
      write_reg(REG_WRAP_LIMIT, ph_limit[p]);
      write_reg(REG_WRAP_MARGIN, ph_margin[p]);
      // one whole phase runs with no idling on either side
      steady <= (p == 3);
      repeat (PHASE_ITEMS) put_tick(pick_source(), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (timebase_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS multi_rate_tick_timebase_unit");
    end else begin
      $display("FAIL multi_rate_tick_timebase_unit");
    end
    $finish;
  end

endmodule

// ===== multi_rate_tick_timebase_unit.f =====
+incdir+hdl
hdl/mrtt_pkg.sv
hdl/mrtt_cfg.sv
hdl/mrtt_step.sv
hdl/multi_rate_tick_timebase_unit.sv
hdl/mrtt_checker.sv
bench/tb_top.sv
